>>> sv/assert_macros.svh
// Assertion macros for the text-mode renderer checks.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked after reset is released
`define TMSR_ASSERT_IMP(name, a, b) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tmsr: same-cycle check failed");
// Next-cycle implication, checked after reset is released
`define TMSR_ASSERT_NXT(name, a, b) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tmsr: next-cycle check failed");
`else
`define TMSR_ASSERT_IMP(name, a, b)
`define TMSR_ASSERT_NXT(name, a, b)
`endif
`endif

>>> sv/tmsr_pkg.sv
// Shared constants, types and tables of the text-mode scan line renderer.
// No dependencies.
package tmsr_pkg;

  localparam int COLUMNS = 40;
  localparam int ROWS    = 25;
  localparam int GLYPHS  = 256;

  localparam int SCREEN_DEPTH = ROWS * COLUMNS;
  localparam int FONT_DEPTH   = GLYPHS * 8;

  localparam int SCR_AW  = (SCREEN_DEPTH > 1) ? $clog2(SCREEN_DEPTH) : 1;
  localparam int GLYPH_W = $clog2(GLYPHS);
  localparam int FONT_AW = GLYPH_W + 3;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Command codes
  localparam logic [1:0] CMD_WR_SCREEN = 2'd0;
  localparam logic [1:0] CMD_WR_FONT   = 2'd1;
  localparam logic [1:0] CMD_FRAME     = 2'd2;
  localparam logic [1:0] CMD_RENDER    = 2'd3;

  localparam logic [31:0] BLACK_RESET = 32'h8888_8888;

  // Pixel masks, bit 7 first
  localparam logic [31:0] M7_A  = 32'hfff0_0000;
  localparam logic [31:0] M6_A  = 32'h000f_ff00;
  localparam logic [31:0] M5_A  = 32'h0000_00ff;
  localparam logic [31:0] M5_B  = 32'hf000_0000;
  localparam logic [31:0] M4_B  = 32'h0fff_0000;
  localparam logic [31:0] M3_B  = 32'h0000_fff0;
  localparam logic [31:0] M2_B  = 32'h0000_000f;
  localparam logic [31:0] M2_C  = 32'hff00_0000;
  localparam logic [31:0] M1_C  = 32'h00ff_f000;
  localparam logic [31:0] M0_C  = 32'h0000_0fff;
  localparam logic [2:0]  SUB_MASK = 3'h7;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } cell_words_t;

  // Screen code to glyph index: code modulo GLYPHS, as a constant table
  typedef logic [7:0] glyph_tab_t [256];

  function automatic glyph_tab_t build_glyph_tab();
    glyph_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(i % GLYPHS);
    end
    return t;
  endfunction

  localparam glyph_tab_t GLYPH_TAB = build_glyph_tab();

endpackage

>>> sv/tmsr_if.sv
// Channel interfaces of the renderer: command input and cell output.
// Depends on tmsr_pkg for nothing but widths fixed here.
interface tmsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] address;
  logic [7:0]  data;
  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;
  logic        cursor_off;

  modport source (output valid, command, address, data, cursor_col, cursor_row,
                  cursor_off, input ready);
  modport sink   (input valid, command, address, data, cursor_col, cursor_row,
                  cursor_off, output ready);
endinterface

interface tmsr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  column;
  logic [31:0] word_first;
  logic [31:0] word_second;
  logic [31:0] word_third;
  logic        last;

  modport source (output valid, column, word_first, word_second, word_third, last,
                  input ready);
  modport sink   (input valid, column, word_first, word_second, word_third, last,
                   output ready);
endinterface

>>> sv/tmsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tmsr_expand.sv
// Pixel expander: one glyph row of 8 pixels to three 32-bit serial words.
// Depends on tmsr_pkg (masks, cell_words_t).
module tmsr_expand (
  input  logic [7:0]           px,
  input  logic [31:0]          black,
  output tmsr_pkg::cell_words_t words
);

  always_comb begin
    words.w0 = black;
    words.w1 = black;
    words.w2 = black;
    if (px[7]) words.w0 = words.w0 | tmsr_pkg::M7_A;
    if (px[6]) words.w0 = words.w0 | tmsr_pkg::M6_A;
    if (px[5]) begin
      words.w0 = words.w0 | tmsr_pkg::M5_A;
      words.w1 = words.w1 | tmsr_pkg::M5_B;
    end
    if (px[4]) words.w1 = words.w1 | tmsr_pkg::M4_B;
    if (px[3]) words.w1 = words.w1 | tmsr_pkg::M3_B;
    if (px[2]) begin
      words.w1 = words.w1 | tmsr_pkg::M2_B;
      words.w2 = words.w2 | tmsr_pkg::M2_C;
    end
    if (px[1]) words.w2 = words.w2 | tmsr_pkg::M1_C;
    if (px[0]) words.w2 = words.w2 | tmsr_pkg::M0_C;
  end

endmodule

>>> sv/text_mode_scanline_renderer_unit.sv
// Text-mode scan line renderer: write, frame start and render transactions.
// Write and frame start transactions give no result and leave the unit ready.
// A render transaction gives COLUMNS cells, each through screen read, font
// read and expand in the shared expander; the cell waits in the load state
// while the output stalls. No new transaction is taken until the last cell
// is loaded. Reset (synchronous, rst_n low) clears the sequencer, output
// valid and line counter and sets the black pattern to BLACK_RESET.
module text_mode_scanline_renderer_unit (
  input  logic              clk,
  input  logic              rst_n,
  tmsr_in_if.sink           in_ch,
  tmsr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  `include "assert_macros.svh"

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCR  = 2'd1;
  localparam logic [1:0] ST_FONT = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [tmsr_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [tmsr_pkg::SCR_AW-1:0]  scr_addr_r, scr_addr_nxt;
  logic [7:0]                   lc_r, lc_nxt;
  logic [4:0]                   row_r, row_nxt;
  logic [2:0]                   sub_r, sub_nxt;
  logic                         vis_r, vis_nxt;
  logic [7:0]                   ccol_r, ccol_nxt;
  logic [7:0]                   crow_r, crow_nxt;
  logic                         coff_r, coff_nxt;
  logic [31:0]                  black_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [5:0]                   out_col_r;
  tmsr_pkg::cell_words_t        out_words_r;
  logic                         out_last_r;

  logic                         in_acc;
  logic                         scr_we, font_we;
  logic [7:0]                   scr_rdata, font_rdata;
  logic [tmsr_pkg::FONT_AW-1:0] font_raddr;
  logic [7:0]                   glyph;
  logic [11:0]                  row_base;
  logic                         col_last;
  logic                         inv;
  logic                         load;
  logic [7:0]                   px;
  tmsr_pkg::cell_words_t        px_words;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Drop stores to addresses beyond each memory
  assign scr_we  = in_acc && (in_ch.command == tmsr_pkg::CMD_WR_SCREEN) &&
                   ({1'b0, in_ch.address} < 12'(tmsr_pkg::SCREEN_DEPTH));
  assign font_we = in_acc && (in_ch.command == tmsr_pkg::CMD_WR_FONT) &&
                   ({1'b0, in_ch.address} < 12'(tmsr_pkg::FONT_DEPTH));

  tmsr_ram #(.WIDTH(8), .DEPTH(tmsr_pkg::SCREEN_DEPTH)) u_screen (
    .clk   (clk),
    .we    (scr_we),
    .waddr (in_ch.address[tmsr_pkg::SCR_AW-1:0]),
    .wdata (in_ch.data),
    .raddr (scr_addr_r),
    .rdata (scr_rdata)
  );

  // Glyph row address from the screen code read last cycle
  assign glyph      = tmsr_pkg::GLYPH_TAB[scr_rdata];
  assign font_raddr = {glyph[tmsr_pkg::GLYPH_W-1:0], sub_r};

  tmsr_ram #(.WIDTH(8), .DEPTH(tmsr_pkg::FONT_DEPTH)) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (in_ch.address[tmsr_pkg::FONT_AW-1:0]),
    .wdata (in_ch.data),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  // Cursor cell inverts; rows past the screen are plain black
  assign inv = vis_r && !coff_r && (ccol_r == 8'(col_r)) && (crow_r == {3'b000, row_r});
  assign px  = vis_r ? (font_rdata ^ (inv ? 8'hff : 8'h00)) : 8'h00;

  tmsr_expand u_expand (
    .px    (px),
    .black (black_r),
    .words (px_words)
  );

  assign row_base = 12'(lc_r[7:3]) * 12'(tmsr_pkg::COLUMNS);
  assign col_last = (col_r == tmsr_pkg::COL_W'(tmsr_pkg::COLUMNS - 1));
  // Load the output register when it is empty or being emptied
  assign load     = (state_r == ST_LOAD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    scr_addr_nxt = scr_addr_r;
    lc_nxt       = lc_r;
    row_nxt      = row_r;
    sub_nxt      = sub_r;
    vis_nxt      = vis_r;
    ccol_nxt     = ccol_r;
    crow_nxt     = crow_r;
    coff_nxt     = coff_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.command)
            tmsr_pkg::CMD_WR_SCREEN,
            tmsr_pkg::CMD_WR_FONT: begin
            end
            tmsr_pkg::CMD_FRAME: begin
              lc_nxt = 8'd0;
            end
            tmsr_pkg::CMD_RENDER: begin
              // Latch the line position and cursor, then advance the counter
              row_nxt      = lc_r[7:3];
              sub_nxt      = lc_r[2:0] & tmsr_pkg::SUB_MASK;
              vis_nxt      = ({1'b0, lc_r[7:3]} < 6'(tmsr_pkg::ROWS));
              scr_addr_nxt = row_base[tmsr_pkg::SCR_AW-1:0];
              col_nxt      = '0;
              ccol_nxt     = in_ch.cursor_col;
              crow_nxt     = in_ch.cursor_row;
              coff_nxt     = in_ch.cursor_off;
              lc_nxt       = lc_r + 8'd1;
              state_nxt    = ST_SCR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCR:  state_nxt = ST_FONT;
      ST_FONT: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (load) begin
          if (col_last) begin
            state_nxt = ST_IDLE;
          end else begin
            col_nxt      = col_r + 1'b1;
            scr_addr_nxt = scr_addr_r + 1'b1;
            state_nxt    = ST_SCR;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lc_r        <= 8'd0;
      black_r     <= tmsr_pkg::BLACK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        black_r <= cfg_wdata;
      end
    end
  end

  // Payload and per-line registers: no reset needed
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    scr_addr_r <= scr_addr_nxt;
    row_r      <= row_nxt;
    sub_r      <= sub_nxt;
    vis_r      <= vis_nxt;
    ccol_r     <= ccol_nxt;
    crow_r     <= crow_nxt;
    coff_r     <= coff_nxt;
    if (load) begin
      out_col_r   <= 6'(col_r);
      out_words_r <= px_words;
      out_last_r  <= col_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.column      = out_col_r;
  assign out_ch.word_first  = out_words_r.w0;
  assign out_ch.word_second = out_words_r.w1;
  assign out_ch.word_third  = out_words_r.w2;
  assign out_ch.last        = out_last_r;

  // A render transaction starts the sweep at column zero
  `TMSR_ASSERT_NXT(a_render_start,
    in_acc && (in_ch.command == tmsr_pkg::CMD_RENDER),
    (state_r == ST_SCR) && (col_r == '0))
  // Loading the final column ends the sweep
  `TMSR_ASSERT_NXT(a_last_ends, load && col_last,
    (state_r == ST_IDLE) && out_ch.valid && out_ch.last)
  // Cells past the screen rows carry the bare black pattern
  `TMSR_ASSERT_NXT(a_black_rows, load && !vis_r,
    (out_ch.word_first == $past(black_r)) && (out_ch.word_third == $past(black_r)))

endmodule
